@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the harmonic sum wave sample block
// Shared shorthand for clocked implications with reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define HSWS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsws assertion failed");

// Next-cycle implication, masked while reset is high.
`define HSWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsws assertion failed");

`endif

@@ hdl/hsws_pkg.sv @@
// ----------------------------------------------------------------------------
// Harmonic sum wave sample package
// Field widths, scaling constants and register indexes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsws_pkg;

   // Field widths.
   localparam int SAMPLE_INDEX_W = 7;
   localparam int CODE_W         = 10;
   localparam int WORD_W         = 17;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE_FUNDAMENTAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE_SECOND      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE_FOURTH      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE_EIGHTH      = 2'd3;

   // Waveform period default.
   localparam int PERIOD_SAMPLES_DEFAULT = 80;

   // Harmonics 1, 2, 4 and 8.
   localparam int HARM_N = 4;
   localparam int CNT_W  = 3;

   // Sine table scaling; pi/2 in Q30.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int SINE_AMPL = 32767;
   localparam int SINE_HALF = 16384;
   localparam int SINE_W    = 16;

   // Datapath widths.
   localparam int SUM_W   = 18;
   localparam int MAG_W   = 17;
   localparam int NUM_W   = 27;
   localparam int DEN_W   = 17;
   localparam int RECIP_W = 13;
   localparam int QUOT_W  = 10;
   localparam int RECIP_SHIFT = 27;

   // Code mapping.
   localparam int CODE_SCALE = 511;
   localparam int CODE_MID   = 512;
   localparam int CODE_MAX   = 1023;
   localparam int DAC_SHIFT  = 6;
   localparam int DAC_BIAS   = 1 << 16;

   // Divisors 32767*count and their reciprocals in Q27.
   localparam int DEN_1 = SINE_AMPL;
   localparam int DEN_2 = 2 * SINE_AMPL;
   localparam int DEN_3 = 3 * SINE_AMPL;
   localparam int DEN_4 = 4 * SINE_AMPL;
   localparam int RECIP_1 = (1 << RECIP_SHIFT) / DEN_1;
   localparam int RECIP_2 = (1 << RECIP_SHIFT) / DEN_2;
   localparam int RECIP_3 = (1 << RECIP_SHIFT) / DEN_3;
   localparam int RECIP_4 = (1 << RECIP_SHIFT) / DEN_4;

endpackage

`default_nettype wire

@@ hdl/hsws_req_if.sv @@
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one sample index per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsws_req_if;
   import hsws_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SAMPLE_INDEX_W-1:0] sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink   (input valid, input sample_index, output ready);
endinterface

`default_nettype wire

@@ hdl/hsws_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Sample result channel
// Valid/ready channel that carries one DAC code and register word per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsws_rsp_if;
   import hsws_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] sample_code;
   logic [WORD_W-1:0] dac_word;
   logic              none_enabled;

   modport source (output valid, output sample_code, output dac_word,
                   output none_enabled, input ready);
   modport sink   (input valid, input sample_code, input dac_word,
                   input none_enabled, output ready);
endinterface

`default_nettype wire

@@ hdl/harmonic_sum_wave_sample.sv @@
// ----------------------------------------------------------------------------
// Harmonic sum wave sample
// Maps a sample index to one DAC sample of the sum of sine harmonics 1, 2, 4
// and 8, averaged over the enabled harmonics.
// ----------------------------------------------------------------------------
//
//   Channel    Direction   Carries
//   req_chan   in          sample_index
//   rsp_chan   out         sample_code, dac_word, none_enabled
//   csr_*      in          four harmonic enable bits, write only
//
// Nine register stages; one word is taken every cycle unless a result-side
// stall has filled every stage.
// Each stage has its own valid bit and holds only when the stage after it
// is full and held, so empty stages fill in during a stall.
// Reset clears the valid bits and the enable registers; the sine table is
// a constant table built at elaboration and needs no fill.
//
`default_nettype none

module harmonic_sum_wave_sample #(
   parameter int PERIOD_SAMPLES = hsws_pkg::PERIOD_SAMPLES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   hsws_req_if.sink                              req_chan,
   hsws_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [hsws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hsws_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import hsws_pkg::*;

   localparam int IDX_W = $clog2(PERIOD_SAMPLES);
   localparam int NS    = 9;
   localparam int IDX_DEPTH = 1 << SAMPLE_INDEX_W;
   localparam longint unsigned N_U = longint'(PERIOD_SAMPLES);

   // ------------------------------------------------------------------
   // Constant tables.
   // ------------------------------------------------------------------

   // Sample index reduced modulo the period.
   logic [IDX_W-1:0] idx_mod_rom [IDX_DEPTH];

   for (genvar i = 0; i < IDX_DEPTH; i++) begin : g_idx_mod
      localparam int MODV = i % PERIOD_SAMPLES;
      assign idx_mod_rom[i] = IDX_W'(MODV);
   end

   // One period of round(32767*sin(2*pi*k/N)), from a Q30 Taylor series on
   // the angle folded into the first quadrant.
   logic signed [SINE_W-1:0] sine_rom [PERIOD_SAMPLES];

   for (genvar k = 0; k < PERIOD_SAMPLES; k++) begin : g_sine
      localparam longint unsigned T0 = 4 * k;
      localparam bit NEG = (T0 >= 2 * N_U);
      localparam longint unsigned T1 = NEG ? T0 - 2 * N_U : T0;
      localparam longint unsigned T  = (T1 > N_U) ? 2 * N_U - T1 : T1;
      localparam longint unsigned X  = (HALF_PI_Q30 * T) / N_U;
      localparam longint unsigned X2 = (X * X) >> 30;
      localparam longint unsigned TERM1 = ((X * X2) >> 30) / 6;
      localparam longint unsigned TERM2 = ((TERM1 * X2) >> 30) / 20;
      localparam longint unsigned TERM3 = ((TERM2 * X2) >> 30) / 42;
      localparam longint unsigned TERM4 = ((TERM3 * X2) >> 30) / 72;
      localparam longint unsigned TERM5 = ((TERM4 * X2) >> 30) / 110;
      localparam longint unsigned TERM6 = ((TERM5 * X2) >> 30) / 156;
      localparam longint unsigned TERM7 = ((TERM6 * X2) >> 30) / 210;
      localparam longint unsigned TERM8 = ((TERM7 * X2) >> 30) / 272;
      localparam longint unsigned ACC_POS = X + TERM2 + TERM4 + TERM6 + TERM8;
      localparam longint unsigned ACC_NEG = TERM1 + TERM3 + TERM5 + TERM7;
      localparam longint unsigned SQ = (ACC_POS > ACC_NEG) ? ACC_POS - ACC_NEG : 0;
      localparam longint unsigned MAG0 = (SQ * SINE_AMPL + (64'd1 << 29)) >> 30;
      localparam longint unsigned MAG1 = (MAG0 > SINE_AMPL) ? SINE_AMPL : MAG0;
      localparam longint unsigned MAG =
         (T == 0)       ? 0 :
         (T == N_U)     ? SINE_AMPL :
         (3 * T == N_U) ? SINE_HALF : MAG1;
      localparam logic signed [SINE_W-1:0] VAL =
         NEG ? -$signed(SINE_W'(MAG)) : $signed(SINE_W'(MAG));
      assign sine_rom[k] = VAL;
   end

   // ------------------------------------------------------------------
   // Helpers.
   // ------------------------------------------------------------------

   // Doubles a table index modulo the period; the input is below the period.
   function automatic logic [IDX_W-1:0] double_mod(input logic [IDX_W-1:0] x);
      logic [IDX_W:0] y;
      y = {x, 1'b0};
      if (y >= (IDX_W + 1)'(PERIOD_SAMPLES)) begin
         y = y - (IDX_W + 1)'(PERIOD_SAMPLES);
      end
      return y[IDX_W-1:0];
   endfunction

   // Divisor 32767*count.
   function automatic logic [DEN_W-1:0] den_of(input logic [CNT_W-1:0] c);
      logic [DEN_W-1:0] d;
      case (c)
         3'd1:    d = DEN_W'(DEN_1);
         3'd2:    d = DEN_W'(DEN_2);
         3'd3:    d = DEN_W'(DEN_3);
         3'd4:    d = DEN_W'(DEN_4);
         default: d = DEN_W'(DEN_1);
      endcase
      return d;
   endfunction

   // Reciprocal of the divisor in Q27, rounded down.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] c);
      logic [RECIP_W-1:0] r;
      case (c)
         3'd1:    r = RECIP_W'(RECIP_1);
         3'd2:    r = RECIP_W'(RECIP_2);
         3'd3:    r = RECIP_W'(RECIP_3);
         3'd4:    r = RECIP_W'(RECIP_4);
         default: r = RECIP_W'(RECIP_1);
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Harmonic enable registers.
   // ------------------------------------------------------------------
   logic [HARM_N-1:0] enables_ff;
   logic [HARM_N-1:0] enables_in;

   always_comb begin
      enables_in = enables_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_ENABLE_FUNDAMENTAL: enables_in[0] = csr_write_data[0];
            REG_ENABLE_SECOND:      enables_in[1] = csr_write_data[0];
            REG_ENABLE_FOURTH:      enables_in[2] = csr_write_data[0];
            REG_ENABLE_EIGHTH:      enables_in[3] = csr_write_data[0];
            default:                enables_in = enables_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enables_ff <= '0;
      end else begin
         enables_ff <= enables_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or the next one moves.
   // ------------------------------------------------------------------
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] adv;
   logic [NS-1:0] valid_up;

   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || rsp_chan.ready;
      for (int s = NS - 2; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign valid_up = {valid_ff[NS-2:0], req_chan.valid};

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         valid_in[s] = adv[s] ? valid_up[s] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = adv[0];

   // ------------------------------------------------------------------
   // Stage datapath registers.
   // ------------------------------------------------------------------
   logic        [IDX_W-1:0]   s0_idx_ff;
   logic        [IDX_W-1:0]   s1_k_ff    [HARM_N];
   logic        [IDX_W-1:0]   s1_k_in    [HARM_N];
   logic signed [SINE_W-1:0]  s2_sine_ff [HARM_N];
   logic signed [SUM_W-1:0]   s3_sum_ff, s3_sum_in;
   logic        [CNT_W-1:0]   s3_cnt_ff, s3_cnt_in;
   logic        [MAG_W-1:0]   s4_mag_ff, s4_mag_in;
   logic                      s4_neg_ff;
   logic        [CNT_W-1:0]   s4_cnt_ff;
   logic        [NUM_W-1:0]   s5_num_ff, s5_num_in;
   logic                      s5_neg_ff;
   logic        [CNT_W-1:0]   s5_cnt_ff;
   logic [NUM_W+RECIP_W-1:0]  s6_prod_ff, s6_prod_in;
   logic        [NUM_W-1:0]   s6_num_ff;
   logic                      s6_neg_ff;
   logic        [CNT_W-1:0]   s6_cnt_ff;
   logic        [QUOT_W-1:0]  s7_quot_ff, s7_quot_in;
   logic        [NUM_W-1:0]   s7_qd_ff, s7_qd_in;
   logic        [NUM_W-1:0]   s7_num_ff;
   logic                      s7_neg_ff;
   logic        [CNT_W-1:0]   s7_cnt_ff;
   logic        [CODE_W-1:0]  code_ff, code_in;
   logic        [WORD_W-1:0]  word_ff, word_in;
   logic                      none_ff, none_in;

   // Table indexes of harmonics 1, 2, 4 and 8.
   always_comb begin
      s1_k_in[0] = s0_idx_ff;
      for (int h = 1; h < HARM_N; h++) begin
         s1_k_in[h] = double_mod(s1_k_in[h-1]);
      end
   end

   // Sum and count of the enabled harmonics.
   always_comb begin
      s3_sum_in = '0;
      s3_cnt_in = '0;
      for (int h = 0; h < HARM_N; h++) begin
         if (enables_ff[h]) begin
            s3_sum_in = s3_sum_in
               + {{(SUM_W - SINE_W){s2_sine_ff[h][SINE_W-1]}}, s2_sine_ff[h]};
            s3_cnt_in = s3_cnt_in + CNT_W'(1);
         end
      end
   end

   // Magnitude of the sum.
   assign s4_mag_in = s3_sum_ff[SUM_W-1] ? MAG_W'(-s3_sum_ff) : MAG_W'(s3_sum_ff);

   // Scaled numerator; a negative sum is biased so the floor becomes a ceiling.
   always_comb begin
      s5_num_in = NUM_W'(s4_mag_ff) * NUM_W'(CODE_SCALE);
      if (s4_neg_ff) begin
         s5_num_in = s5_num_in + NUM_W'(den_of(s4_cnt_ff)) - NUM_W'(1);
      end
   end

   // Quotient estimate by reciprocal, low by at most one.
   assign s6_prod_in = (NUM_W + RECIP_W)'(s5_num_ff)
                     * (NUM_W + RECIP_W)'(recip_of(s5_cnt_ff));
   assign s7_quot_in = s6_prod_ff[RECIP_SHIFT +: QUOT_W];
   assign s7_qd_in   = NUM_W'(s7_quot_in) * NUM_W'(den_of(s6_cnt_ff));

   // Quotient correction, code mapping and clamp.
   always_comb begin
      logic [NUM_W-1:0]         rem;
      logic [QUOT_W-1:0]        quot;
      logic signed [CODE_W+1:0] code_s;
      rem  = s7_num_ff - s7_qd_ff;
      quot = s7_quot_ff;
      if (rem >= NUM_W'(den_of(s7_cnt_ff))) begin
         quot = quot + QUOT_W'(1);
      end
      if (s7_neg_ff) begin
         code_s = (CODE_W + 2)'(CODE_MID) - $signed({2'b00, quot});
      end else begin
         code_s = (CODE_W + 2)'(CODE_MID) + $signed({2'b00, quot});
      end
      if (code_s < 0) begin
         code_s = '0;
      end else if (code_s > (CODE_W + 2)'(CODE_MAX)) begin
         code_s = (CODE_W + 2)'(CODE_MAX);
      end
      none_in = (s7_cnt_ff == '0);
      if (none_in) begin
         code_in = CODE_W'(CODE_MID);
      end else begin
         code_in = code_s[CODE_W-1:0];
      end
      word_in = (WORD_W'(code_in) << DAC_SHIFT) | WORD_W'(DAC_BIAS);
   end

   // Payload registers move with their stage.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_idx_ff <= idx_mod_rom[req_chan.sample_index];
      end
      if (adv[1]) begin
         s1_k_ff <= s1_k_in;
      end
      if (adv[2]) begin
         for (int h = 0; h < HARM_N; h++) begin
            s2_sine_ff[h] <= sine_rom[s1_k_ff[h]];
         end
      end
      if (adv[3]) begin
         s3_sum_ff <= s3_sum_in;
         s3_cnt_ff <= s3_cnt_in;
      end
      if (adv[4]) begin
         s4_mag_ff <= s4_mag_in;
         s4_neg_ff <= s3_sum_ff[SUM_W-1];
         s4_cnt_ff <= s3_cnt_ff;
      end
      if (adv[5]) begin
         s5_num_ff <= s5_num_in;
         s5_neg_ff <= s4_neg_ff;
         s5_cnt_ff <= s4_cnt_ff;
      end
      if (adv[6]) begin
         s6_prod_ff <= s6_prod_in;
         s6_num_ff  <= s5_num_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_cnt_ff  <= s5_cnt_ff;
      end
      if (adv[7]) begin
         s7_quot_ff <= s7_quot_in;
         s7_qd_ff   <= s7_qd_in;
         s7_num_ff  <= s6_num_ff;
         s7_neg_ff  <= s6_neg_ff;
         s7_cnt_ff  <= s6_cnt_ff;
      end
      if (adv[8]) begin
         code_ff <= code_in;
         word_ff <= word_in;
         none_ff <= none_in;
      end
   end

   // Result word.
   assign rsp_chan.valid        = valid_ff[NS-1];
   assign rsp_chan.sample_code  = code_ff;
   assign rsp_chan.dac_word     = word_ff;
   assign rsp_chan.none_enabled = none_ff;

endmodule

`default_nettype wire

@@ hdl/hsws_checker.sv @@
// ----------------------------------------------------------------------------
// Harmonic sum wave sample checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hsws_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [hsws_pkg::CODE_W-1:0]   rsp_sample_code,
   input wire logic [hsws_pkg::WORD_W-1:0]   rsp_dac_word,
   input wire logic                          rsp_none_enabled
);
   import hsws_pkg::*;

   localparam logic [CODE_W-1:0] MIDSCALE = CODE_W'(CODE_MID);

   // Register word formed from the code on offer, the whole payload, and a stall.
   logic [WORD_W-1:0]      word_from_code;
   logic [CODE_W+WORD_W:0] rsp_payload;
   logic                   rsp_stall;

   assign word_from_code = {1'b1, rsp_sample_code, {DAC_SHIFT{1'b0}}};
   assign rsp_payload    = {rsp_sample_code, rsp_dac_word, rsp_none_enabled};
   assign rsp_stall      = rsp_valid && !rsp_ready;

   // The register word is the code moved up with the bias bit set.
   `HSWS_ASSERT_IMPL(a_word_format, rsp_valid, rsp_dac_word == word_from_code)

   // With no harmonic enabled the code sits at midscale.
   `HSWS_ASSERT_IMPL(a_none_midscale, rsp_valid && rsp_none_enabled, rsp_sample_code == MIDSCALE)

   // A held word keeps its value.
   `HSWS_ASSERT_NEXT(a_hold, rsp_stall, rsp_valid && $stable(rsp_payload))

   // Nothing is offered in the first cycle after reset.
   `HSWS_ASSERT_IMPL(a_reset_empty, $fell(reset), !rsp_valid)

endmodule

bind harmonic_sum_wave_sample hsws_checker u_hsws_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_sample_code  (rsp_chan.sample_code),
   .rsp_dac_word     (rsp_chan.dac_word),
   .rsp_none_enabled (rsp_chan.none_enabled)
);

`default_nettype wire

@@ tb/sv/tb_harmonic_sum_wave_sample.sv @@
// ----------------------------------------------------------------------------
// Harmonic sum wave sample testbench
// Sends sample indexes through the request channel under several harmonic
// enable settings and compares every result word, field by field, with a typed
// sample or one computed here from the same Q30 sine series and code mapping.
// A short table of directed words comes first, then random batches with
// random gaps on both channels, one long result-side hold-off and a drain
// before every register change.
// ----------------------------------------------------------------------------

module tb_harmonic_sum_wave_sample;
   timeunit 1ns;
   timeprecision 1ps;

   import hsws_pkg::*;

   localparam int PERIOD          = PERIOD_SAMPLES_DEFAULT;
   localparam int RANDOM_ITEMS    = 800;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 20;
   localparam int NUM_DIRECTED    = 23;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [WORD_W-1:0] word;
      logic              none;
   } sample_result_type;

   typedef struct packed {
      logic [HARM_N-1:0]         enables;
      logic [SAMPLE_INDEX_W-1:0] index;
      logic                      typed;
      sample_result_type         want;
   } stim_row_type;

   // Directed words: enables, index, whether the result is typed in, result.
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{4'b0000, 7'd0,   1'b1, '{10'd512,  17'd98304,  1'b1}},
      '{4'b0000, 7'd127, 1'b1, '{10'd512,  17'd98304,  1'b1}},
      '{4'b0000, 7'd85,  1'b1, '{10'd512,  17'd98304,  1'b1}},
      '{4'b0001, 7'd20,  1'b1, '{10'd1023, 17'd131008, 1'b0}},
      '{4'b0001, 7'd60,  1'b1, '{10'd1,    17'd65600,  1'b0}},
      '{4'b0001, 7'd0,   1'b1, '{10'd512,  17'd98304,  1'b0}},
      '{4'b0001, 7'd100, 1'b1, '{10'd1023, 17'd131008, 1'b0}},
      '{4'b0001, 7'd42,  1'b0, '0},
      '{4'b0010, 7'd10,  1'b1, '{10'd1023, 17'd131008, 1'b0}},
      '{4'b0010, 7'd30,  1'b1, '{10'd1,    17'd65600,  1'b0}},
      '{4'b0100, 7'd5,   1'b1, '{10'd1023, 17'd131008, 1'b0}},
      '{4'b0100, 7'd125, 1'b1, '{10'd1023, 17'd131008, 1'b0}},
      '{4'b1000, 7'd3,   1'b0, '0},
      '{4'b1000, 7'd127, 1'b0, '0},
      '{4'b1111, 7'd0,   1'b1, '{10'd512,  17'd98304,  1'b0}},
      '{4'b1111, 7'd40,  1'b1, '{10'd512,  17'd98304,  1'b0}},
      '{4'b1111, 7'd7,   1'b0, '0},
      '{4'b1111, 7'd127, 1'b0, '0},
      '{4'b0011, 7'd85,  1'b0, '0},
      '{4'b0101, 7'd13,  1'b0, '0},
      '{4'b1010, 7'd64,  1'b0, '0},
      '{4'b0110, 7'd77,  1'b0, '0},
      '{4'b0000, 7'd64,  1'b1, '{10'd512,  17'd98304,  1'b1}}
   };

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   hsws_req_if req_if ();
   hsws_rsp_if rsp_if ();

   harmonic_sum_wave_sample u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Expected samples in order, and the one that goes with the word on offer.
   sample_result_type pending_samples [$];
   sample_result_type offer_want;
   logic [HARM_N-1:0] enables_now;
   int                mismatch_count;
   int                random_items;
   bit                gaps_on;
   bit                hold_off_armed;

   // Rounded sine at step k of the period, from the Q30 Taylor series.
   function automatic int harmonic_sine(input int unsigned k);
      longint unsigned n, t, x, x2, term, acc_pos, acc_neg, sq, mag, i;
      bit neg;
      n = PERIOD;
      t = 4 * (k % n);
      neg = 1'b0;
      if (t >= 2 * n) begin
         t = t - 2 * n;
         neg = 1'b1;
      end
      if (t > n) t = 2 * n - t;
      if (t == 0) return 0;
      if (t == n) begin
         mag = SINE_AMPL;
      end else if (3 * t == n) begin
         mag = SINE_HALF;
      end else begin
         x = (HALF_PI_Q30 * t) / n;
         x2 = (x * x) >> 30;
         term = x;
         acc_pos = x;
         acc_neg = 0;
         for (i = 1; i <= 8; i++) begin
            term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
            if (i[0]) acc_neg += term;
            else acc_pos += term;
         end
         sq = (acc_pos > acc_neg) ? acc_pos - acc_neg : 64'd0;
         mag = (sq * SINE_AMPL + (64'd1 << 29)) >> 30;
         if (mag > SINE_AMPL) mag = SINE_AMPL;
      end
      return neg ? -int'(mag) : int'(mag);
   endfunction

   // Average of the enabled harmonics, mapped to a DAC code and word.
   function automatic sample_result_type predict_sample(input logic [HARM_N-1:0] enables,
                                                        input logic [SAMPLE_INDEX_W-1:0] idx);
      int                sum, count, code;
      longint            num, den, q;
      sample_result_type r;
      sum = 0;
      count = 0;
      for (int h = 0; h < HARM_N; h++) begin
         if (enables[h]) begin
            sum += harmonic_sine((32'd1 << h) * idx);
            count++;
         end
      end
      if (count == 0) begin
         r.code = CODE_W'(CODE_MID);
         r.word = (WORD_W'(CODE_MID) << DAC_SHIFT) | WORD_W'(DAC_BIAS);
         r.none = 1'b1;
         return r;
      end
      num = longint'(CODE_SCALE) * sum;
      den = longint'(SINE_AMPL) * count;
      // Division rounds toward minus infinity.
      if (num >= 0) q = num / den;
      else q = -((-num + den - 1) / den);
      code = CODE_MID + int'(q);
      if (code < 0) code = 0;
      if (code > CODE_MAX) code = CODE_MAX;
      r.code = CODE_W'(code);
      r.word = (WORD_W'(code) << DAC_SHIFT) | WORD_W'(DAC_BIAS);
      r.none = 1'b0;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one; none while gaps are off.
   function automatic int pick_gap();
      int roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("ERROR at %0t ns: %s got %0d, expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   // Offers one index until it is taken, then idles for a random gap.
   task automatic offer_index(input logic [SAMPLE_INDEX_W-1:0] idx,
                              input sample_result_type want);
      int gap;
      req_if.sample_index <= idx;
      req_if.valid        <= 1'b1;
      offer_want          <= want;
      do @(posedge clock); while (!req_if.ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every expected word has come back.
   task automatic wait_idle();
      if (req_if.valid) req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   // Writes all four enable registers, one per cycle.
   task automatic apply_enables(input logic [HARM_N-1:0] mask);
      logic [CSR_INDEX_W-1:0] regs [HARM_N] = '{REG_ENABLE_FUNDAMENTAL, REG_ENABLE_SECOND,
                                                REG_ENABLE_FOURTH, REG_ENABLE_EIGHTH};
      enables_now = mask;
      for (int h = 0; h < HARM_N; h++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= regs[h];
         csr_write_data   <= mask[h];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off when armed.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   // Checks each result word, then records the request word taken this edge.
   always @(posedge clock) begin : check_results
      sample_result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_samples.size() == 0) begin
               report_mismatch("unexpected result word, sample_code", rsp_if.sample_code, -1);
            end else begin
               want = pending_samples.pop_front();
               if (rsp_if.sample_code !== want.code)
                  report_mismatch("sample_code", rsp_if.sample_code, want.code);
               if (rsp_if.dac_word !== want.word)
                  report_mismatch("dac_word", rsp_if.dac_word, want.word);
               if (rsp_if.none_enabled !== want.none)
                  report_mismatch("none_enabled", rsp_if.none_enabled, want.none);
            end
         end
         if (req_if.valid && req_if.ready) pending_samples.push_back(offer_want);
      end
   end

   // Stimulus.
   initial begin
      logic [HARM_N-1:0]         mask;
      logic [SAMPLE_INDEX_W-1:0] idx;
      int                        phase, batch, start;
      bit                        sweep;

      mismatch_count = 0;
      random_items   = 0;
      gaps_on        = 1'b1;
      hold_off_armed = 1'b0;
      enables_now    = '0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.sample_index <= '0;
      offer_want          <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= REG_ENABLE_FUNDAMENTAL;
      csr_write_data      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; the first rows run on the enables left by reset.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].enables != enables_now) begin
            wait_idle();
            apply_enables(directed_rows[r].enables);
         end
         offer_index(directed_rows[r].index,
                     directed_rows[r].typed ? directed_rows[r].want
                                            : predict_sample(enables_now,
                                                             directed_rows[r].index));
      end

      // Random batches, each under its own enable setting.
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         if (phase == 0) mask = '1;
         else if (phase == 1) mask = '0;
         else mask = HARM_N'($urandom_range(0, 15));
         apply_enables(mask);
         gaps_on = ($urandom_range(0, 3) != 0);
         // One batch runs into a long result-side hold-off at full input rate.
         if (phase == 2) begin
            gaps_on = 1'b0;
            hold_off_armed = 1'b1;
         end
         batch = $urandom_range(20, 60);
         sweep = ($urandom_range(0, 2) == 0);
         start = $urandom_range(0, PERIOD - 1);
         for (int i = 0; i < batch; i++) begin
            // A sweep walks the period in order; otherwise indexes are random,
            // some of them past the period so that they wrap.
            if (sweep) idx = SAMPLE_INDEX_W'((start + i) % PERIOD);
            else if ($urandom_range(0, 99) < 85) idx = SAMPLE_INDEX_W'($urandom_range(0, PERIOD - 1));
            else idx = SAMPLE_INDEX_W'($urandom_range(PERIOD, 127));
            offer_index(idx, predict_sample(enables_now, idx));
            random_items++;
         end
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
